@@ hdl/rme_pkg.sv @@
// Shared types, constants and tables for the ZYX Euler angle pipeline.
`default_nettype none
package rme_pkg;

    localparam int FieldW    = 16;
    localparam int NumIn     = 7;
    localparam int PayW      = FieldW * NumIn;
    localparam int ThrW      = 15;
    localparam int SqW       = 32;
    localparam int SqrtSteps = 16;
    localparam int CordSteps = 17;
    localparam int CordW     = 31;
    localparam int AngW      = 21;
    localparam int StepW     = 5;
    localparam int RootStepW = 4;

    localparam logic signed [AngW-1:0] AngPi    = AngW'(205887);
    localparam logic signed [17:0]     AngLimit = 18'sd25736;

    // One CORDIC lane: vector and angle accumulator.
    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [AngW-1:0]  z;
    } t_lane;

    // Per item flags riding along the CORDIC stages.
    typedef struct packed {
        logic zero_roll;
        logic zero_pitch;
        logic zero_yaw;
        logic gimbal;
    } t_flags;

    // Elementary angles atan(2^-i) in units of 2^-16 rad.
    function automatic logic signed [AngW-1:0] f_atan(input logic [StepW-1:0] step);
        logic signed [AngW-1:0] t;
        unique case (step)
            5'd0:    t = AngW'(51472);
            5'd1:    t = AngW'(30386);
            5'd2:    t = AngW'(16055);
            5'd3:    t = AngW'(8150);
            5'd4:    t = AngW'(4091);
            5'd5:    t = AngW'(2047);
            5'd6:    t = AngW'(1024);
            5'd7:    t = AngW'(512);
            5'd8:    t = AngW'(256);
            5'd9:    t = AngW'(128);
            5'd10:   t = AngW'(64);
            5'd11:   t = AngW'(32);
            5'd12:   t = AngW'(16);
            5'd13:   t = AngW'(8);
            5'd14:   t = AngW'(4);
            5'd15:   t = AngW'(2);
            5'd16:   t = AngW'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

@@ hdl/rme_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
`default_nettype none
module rme_sqrt_cell (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire  [rme_pkg::RootStepW-1:0]        i_step,
    input  wire  [rme_pkg::SqW-1:0]              i_rem,
    input  wire  [rme_pkg::SqW-1:0]              i_root,
    input  wire  [rme_pkg::PayW-1:0]             i_pay,
    output logic [rme_pkg::SqW-1:0]              o_rem,
    output logic [rme_pkg::SqW-1:0]              o_root,
    output logic [rme_pkg::PayW-1:0]             o_pay
);
    import rme_pkg::*;

    logic [4:0]    w_sh;
    logic [SqW-1:0] w_bit;
    logic [SqW:0]  w_trial;
    logic [SqW-1:0] n_rem;
    logic [SqW-1:0] n_root;

    // Trial subtract of root plus the current bit weight
    always_comb begin
        w_sh    = {4'(RootStepW'(SqrtSteps - 1) - i_step), 1'b0};
        w_bit   = SqW'(1) << w_sh;
        w_trial = {1'b0, i_root} + {1'b0, w_bit};
        if ({1'b0, i_rem} >= w_trial) begin
            n_rem  = i_rem - w_trial[SqW-1:0];
            n_root = (i_root >> 1) + w_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    // Advance to the neighbor cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
            o_pay  <= i_pay;
        end
    end

endmodule
`default_nettype wire

@@ hdl/rme_cordic_cell.sv @@
// One vectoring micro-rotation of the CORDIC chain.
`default_nettype none
module rme_cordic_cell (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  [rme_pkg::StepW-1:0]      i_step,
    input  rme_pkg::t_lane                 i_lane,
    output rme_pkg::t_lane                 o_lane
);
    import rme_pkg::*;

    logic signed [CordW-1:0] w_xs;
    logic signed [CordW-1:0] w_ys;
    t_lane                   n_lane;

    // Rotate toward the x axis, old x and y on both sides
    always_comb begin
        w_xs = i_lane.x >>> i_step;
        w_ys = i_lane.y >>> i_step;
        if (i_lane.y > 0) begin
            n_lane.x = i_lane.x + w_ys;
            n_lane.y = i_lane.y - w_xs;
            n_lane.z = i_lane.z + f_atan(i_step);
        end else begin
            n_lane.x = i_lane.x - w_ys;
            n_lane.y = i_lane.y + w_xs;
            n_lane.z = i_lane.z - f_atan(i_step);
        end
    end

    // Hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lane <= n_lane;
        end
    end

endmodule
`default_nettype wire

@@ hdl/rotation_matrix_to_euler_zyx_top.sv @@
// Top level: rotation matrix to ZYX Euler angles, square root and CORDIC chains.
//
//  channel   direction  handshake                       request contents
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata: m00..m12, 7 x Q2.14
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: roll,pitch,yaw; tuser: gimbal
//  cfg       in         i_cfg_valid / o_cfg_ready       gimbal_threshold, 15 bits
//
// One request is taken every cycle while the output is not stalled; the stages are one square, 16 square
// root cells, one operand select, 17 CORDIC cells, one output register.
// A stalled output freezes the whole chain, so s_axis_tready follows the output side.
// Synchronous active low reset clears the valid chain and sets the threshold to 1.
`default_nettype none
module rotation_matrix_to_euler_zyx_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [111:0] s_axis_tdata,   // m00, m10, m20, m21, m22, m11, m12 (16 bits each)
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // roll, pitch, yaw (16 bits each)
    output logic         m_axis_tuser,   // gimbal_lock
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [14:0]  i_cfg_data
);
    import rme_pkg::*;

    localparam int VldN = 1 + SqrtSteps + 1 + CordSteps;

    logic                    w_en;
    logic [VldN-1:0]         r_vld;
    logic [ThrW-1:0]         r_thr;

    logic signed [SqW-1:0]   w_a0;
    logic signed [SqW-1:0]   w_a1;
    logic [SqW-1:0]          r_sq0;
    logic [SqW-1:0]          r_sq1;
    logic [PayW-1:0]         r_pay1;

    logic [SqW-1:0]          w_rem  [0:SqrtSteps];
    logic [SqW-1:0]          w_root [0:SqrtSteps];
    logic [PayW-1:0]         w_pay  [0:SqrtSteps];

    t_lane                   w_roll  [0:CordSteps];
    t_lane                   w_pitch [0:CordSteps];
    t_lane                   w_yaw   [0:CordSteps];
    t_flags                  r_flg   [0:CordSteps];

    logic signed [FieldW:0]  w_sy;
    logic                    w_sing;
    logic signed [FieldW:0]  w_m00, w_m10, w_m20, w_m21, w_m22, w_m11, w_m12;
    logic signed [FieldW:0]  w_ry, w_rx;
    t_flags                  n_flg;

    // Pre-rotate into the right half plane and scale by 4096
    function automatic t_lane f_prep(input logic signed [FieldW:0] y,
                                     input logic signed [FieldW:0] x);
        t_lane l;
        l.x = {{(CordW-FieldW-13){x[FieldW]}}, x, 12'd0};
        l.y = {{(CordW-FieldW-13){y[FieldW]}}, y, 12'd0};
        l.z = '0;
        if (x < 0) begin
            l.x = -l.x;
            l.y = -l.y;
            l.z = (y >= 0) ? AngPi : -AngPi;
        end
        return l;
    endfunction

    // Round to Q3.13 and clamp; forced zero where atan2 is undefined and for yaw in gimbal lock
    function automatic logic [FieldW-1:0] f_angle(input logic signed [AngW-1:0] z,
                                                  input logic zero);
        logic signed [AngW-1:0] s;
        logic signed [17:0]     q;
        s = z + AngW'(4);
        q = 18'(s >>> 3);
        if (q > AngLimit)  q = AngLimit;
        if (q < -AngLimit) q = -AngLimit;
        return zero ? '0 : q[FieldW-1:0];
    endfunction

    // Whole chain moves while the output slot is free or being drained
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrW'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            r_vld         <= {r_vld[VldN-2:0], s_axis_tvalid};
            m_axis_tvalid <= r_vld[VldN-1];
        end
    end

    // Widen the first column entries before squaring
    assign w_a0 = SqW'($signed(s_axis_tdata[15:0]));
    assign w_a1 = SqW'($signed(s_axis_tdata[31:16]));

    // Square the first column entries
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq0  <= $unsigned(w_a0 * w_a0);
            r_sq1  <= $unsigned(w_a1 * w_a1);
            r_pay1 <= s_axis_tdata;
        end
    end

    assign w_rem[0]  = r_sq0 + r_sq1;
    assign w_root[0] = '0;
    assign w_pay[0]  = r_pay1;

    // Square root chain
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        rme_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (RootStepW'(k)),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .i_pay  (w_pay[k]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1]),
            .o_pay  (w_pay[k+1])
        );
    end

    // Select operands for the three angles
    always_comb begin
        w_sy   = {1'b0, w_root[SqrtSteps][FieldW-1:0]};
        w_sing = w_root[SqrtSteps][FieldW-1:0] < {1'b0, r_thr};
        w_m00  = {w_pay[SqrtSteps][15],  w_pay[SqrtSteps][15:0]};
        w_m10  = {w_pay[SqrtSteps][31],  w_pay[SqrtSteps][31:16]};
        w_m20  = {w_pay[SqrtSteps][47],  w_pay[SqrtSteps][47:32]};
        w_m21  = {w_pay[SqrtSteps][63],  w_pay[SqrtSteps][63:48]};
        w_m22  = {w_pay[SqrtSteps][79],  w_pay[SqrtSteps][79:64]};
        w_m11  = {w_pay[SqrtSteps][95],  w_pay[SqrtSteps][95:80]};
        w_m12  = {w_pay[SqrtSteps][111], w_pay[SqrtSteps][111:96]};
        w_ry   = w_sing ? -w_m12 : w_m21;
        w_rx   = w_sing ? w_m11  : w_m22;
        n_flg.zero_roll  = (w_ry == 0) && (w_rx == 0);
        n_flg.zero_pitch = (w_m20 == 0) && (w_sy == 0);
        n_flg.zero_yaw   = w_sing || ((w_m10 == 0) && (w_m00 == 0));
        n_flg.gimbal     = w_sing;
    end

    // Register the pre-rotated lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_roll[0]  <= f_prep(w_ry, w_rx);
            w_pitch[0] <= f_prep(-w_m20, w_sy);
            w_yaw[0]   <= f_prep(w_m10, w_m00);
            r_flg[0]   <= n_flg;
        end
    end

    // CORDIC chains, three lanes side by side
    for (genvar k = 0; k < CordSteps; k++) begin : g_cord
        rme_cordic_cell u_roll (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (StepW'(k)),
            .i_lane (w_roll[k]),
            .o_lane (w_roll[k+1])
        );
        rme_cordic_cell u_pitch (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (StepW'(k)),
            .i_lane (w_pitch[k]),
            .o_lane (w_pitch[k+1])
        );
        rme_cordic_cell u_yaw (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (StepW'(k)),
            .i_lane (w_yaw[k]),
            .o_lane (w_yaw[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_flg[k+1] <= r_flg[k];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata[15:0]  <= f_angle(w_roll[CordSteps].z,  r_flg[CordSteps].zero_roll);
            m_axis_tdata[31:16] <= f_angle(w_pitch[CordSteps].z, r_flg[CordSteps].zero_pitch);
            m_axis_tdata[47:32] <= f_angle(w_yaw[CordSteps].z,   r_flg[CordSteps].zero_yaw);
            m_axis_tuser        <= r_flg[CordSteps].gimbal;
        end
    end

`ifndef SYNTH
    a_yaw_zero_on_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[47:32] == 16'd0)
        else $error("yaw not zero in gimbal lock");
    a_pitch_half_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd14282) &&
                          ($signed(m_axis_tdata[31:16]) >= -16'sd14282))
        else $error("pitch outside right half plane range");
    a_roll_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd25736) &&
                          ($signed(m_axis_tdata[15:0]) >= -16'sd25736))
        else $error("roll outside clamp range");
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("chain moved during stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the rotation matrix to ZYX Euler angle pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Expected angle store: one entry per accepted matrix, checked in order.
class euler_board;
    logic [15:0] exp_roll[$];
    logic [15:0] exp_pitch[$];
    logic [15:0] exp_yaw[$];
    logic        exp_gimbal[$];
    int          n_fail;
    int          n_checked;
    int          n_gimbal;

    function new();
        n_fail = 0;
        n_checked = 0;
        n_gimbal = 0;
    endfunction

    // Vectoring CORDIC angle, result in Q3.13 radians.
    static function automatic longint cordic_angle(longint yi, longint xi);
        longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                          128, 64, 32, 16, 8, 4, 2, 1};
        longint x, y, z, xs, ys, q;
        x = xi * 4096;
        y = yi * 4096;
        z = 0;
        if (xi == 0 && yi == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + t[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - t[i];
            end
        end
        q = (z + 4) >>> 3;
        if (q > 25736) q = 25736;
        if (q < -25736) q = -25736;
        return q;
    endfunction

    static function automatic longint floor_root(longint n);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= n) r = r + 1;
        return r;
    endfunction

    // Note one accepted matrix and queue its expected angles.
    function void note_matrix(logic [111:0] d, logic [14:0] thr);
        longint m[7];
        longint sy, rl, pt, yw;
        bit g;
        for (int k = 0; k < 7; k++) m[k] = longint'($signed(d[16*k +: 16]));
        sy = floor_root(m[0] * m[0] + m[1] * m[1]);
        g = sy < longint'(thr);
        pt = cordic_angle(-m[2], sy);
        if (!g) begin
            rl = cordic_angle(m[3], m[4]);
            yw = cordic_angle(m[1], m[0]);
        end else begin
            rl = cordic_angle(-m[6], m[5]);
            yw = 0;
        end
        exp_roll.push_back(rl[15:0]);
        exp_pitch.push_back(pt[15:0]);
        exp_yaw.push_back(yw[15:0]);
        exp_gimbal.push_back(g);
    endfunction

    // Check one output request against the oldest expectation.
    function void check_angles(logic [47:0] d, logic u);
        logic [15:0] er, ep, ey;
        logic eg;
        if (exp_roll.size() == 0) begin
            $error("unexpected result %h %b", d, u);
            n_fail++;
            return;
        end
        er = exp_roll.pop_front();
        ep = exp_pitch.pop_front();
        ey = exp_yaw.pop_front();
        eg = exp_gimbal.pop_front();
        n_checked++;
        if (eg) n_gimbal++;
        if (d[15:0] !== er) begin
            $error("roll exp %0d got %0d", $signed(er), $signed(d[15:0]));
            n_fail++;
        end
        if (d[31:16] !== ep) begin
            $error("pitch exp %0d got %0d", $signed(ep), $signed(d[31:16]));
            n_fail++;
        end
        if (d[47:32] !== ey) begin
            $error("yaw exp %0d got %0d", $signed(ey), $signed(d[47:32]));
            n_fail++;
        end
        if (u !== eg) begin
            $error("gimbal_lock exp %0b got %0b", eg, u);
            n_fail++;
        end
    endfunction

    function int pending();
        return exp_roll.size();
    endfunction
endclass

module tb;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [14:0]  i_cfg_data;

    localparam int Latency = 36;

    euler_board  board;
    logic [14:0] cur_thr;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;
    int          n_sent;

    rotation_matrix_to_euler_zyx_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_angles(m_axis_tdata, m_axis_tuser);
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Write the threshold register; block is idle here.
    task automatic write_threshold(input logic [14:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_thr = v;
    endtask

    // Offer one matrix, with a random idle gap first.
    task automatic send_matrix(input logic [111:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_matrix(d, cur_thr);
        n_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic [111:0] pack7(input int a, b, c, d, e, f, g);
        return {16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // Random element: mostly in range, sometimes full 16-bit noise.
    function automatic int rnd_elem();
        case ($urandom_range(9))
            0:       return int'($urandom_range(65535)) - 32768;
            1:       return 0;
            2:       return ($urandom_range(1) ? 16384 : -16384);
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // Random matrix; some items push the first column near zero.
    function automatic logic [111:0] rnd_matrix();
        int e[7];
        for (int k = 0; k < 7; k++) e[k] = rnd_elem();
        if ($urandom_range(4) == 0) begin
            e[0] = int'($urandom_range(8)) - 4;
            e[1] = int'($urandom_range(8)) - 4;
        end
        return pack7(e[0], e[1], e[2], e[3], e[4], e[5], e[6]);
    endfunction

    initial begin
        board = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        cur_thr = 15'd1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        n_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, extremes, zero operands, gimbal lock, noise.
        send_matrix(pack7(16384, 0, 0, 0, 16384, 16384, 0));
        send_matrix(pack7(0, 0, 0, 0, 0, 0, 0));
        send_matrix(pack7(0, 0, -16384, 16384, 0, 16384, 0));
        send_matrix(pack7(0, 0, 16384, 0, -16384, 0, 16384));
        send_matrix(pack7(-16384, 0, 0, 0, -16384, -16384, 0));
        send_matrix(pack7(-16384, -1, 0, -1, -16384, -16384, 1));
        send_matrix(pack7(-16384, 1, 1, 1, -16384, -16384, -1));
        send_matrix(pack7(16384, 16384, -16384, -16384, 16384, -16384, 16384));
        send_matrix(pack7(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_matrix(pack7(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(pack7(-32768, 32767, 0, 32767, -32768, 32767, -32768));
        send_matrix(pack7(1, 0, 0, 0, 1, 1, 0));
        send_matrix(pack7(0, 1, 5, -3, 0, 0, 7));
        send_matrix(pack7(11585, 11585, 0, 11585, 11585, 11585, -11585));
        send_matrix(112'h5555_aaaa_5555_aaaa_5555_aaaa_5555);
        send_matrix(112'haaaa_5555_aaaa_5555_aaaa_5555_aaaa);
        drain();

        // Threshold extremes: zero, max, and above one.
        write_threshold(15'd0);
        send_matrix(pack7(0, 0, 100, 3, 4, 5, 6));
        send_matrix(pack7(1, 0, 100, 3, 4, 5, 6));
        drain();
        write_threshold(15'h7fff);
        send_matrix(pack7(16384, 16384, 100, 3, 4, 5, 6));
        send_matrix(pack7(-32768, -32768, 100, 3, 4, 5, 6));
        drain();

        // Random phases with different thresholds and idle mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_threshold(15'd1);     send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin write_threshold(15'd3);     send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin write_threshold(15'd16384); send_idle_pct = 0;  recv_stall_pct = 65; end
                3: begin write_threshold(15'd2);     send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin
                    write_threshold(15'd5); send_idle_pct = 0; recv_stall_pct = 0;
                    hold_off = 200;
                end
            endcase
            for (int n = 0; n < 85; n++) send_matrix(rnd_matrix());
            drain();
        end

        $display("tb: %0d matrices sent, %0d results checked, %0d in gimbal lock",
                 n_sent, board.n_checked, board.n_gimbal);
        $display("tb: thresholds 0..32767, idle and stall mixes, one long output hold-off");
        if (board.n_fail == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
